>>> src/psw_pkg.sv
// Shared types, constants and helpers for the particle swarm step unit.
`default_nettype none
package psw_pkg;

  localparam int POS_W = 32;
  localparam int FIT_W = 48;
  localparam int SQ_W  = 64;
  localparam int W_W   = 18;
  localparam int F_W   = 19;
  localparam int E_W   = 17;
  localparam int C_W   = 20;
  localparam int IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [FIT_W-1:0] FIT_MAX   = 48'hFFFF_FFFF_FFFF;
  // 99999.0 in unsigned Q32.16.
  localparam logic [FIT_W-1:0] FIRST_REF = 48'h0001_869F_0000;

  localparam logic           RST_MODE    = 1'b0;
  localparam logic [W_W-1:0] RST_INERTIA = 18'd47776;
  localparam logic [F_W-1:0] RST_COG     = 19'd134349;
  localparam logic [F_W-1:0] RST_SOC     = 19'd134349;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_INERTIA = 2'd1,
    CFG_COG     = 2'd2,
    CFG_SOC     = 2'd3
  } cfg_idx_t;

  // Control for a fitness accumulator.
  typedef struct packed {
    logic clr;
    logic vld;
  } fit_ctl_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PB_RD, ST_PB_SQ, ST_PB_WAIT, ST_PB_CMP,
    ST_CP_RD, ST_CP_WR,
    ST_GF_FEED, ST_GF_WAIT, ST_GF_SET,
    ST_GS_RD, ST_GS_CMP,
    ST_GC_RD, ST_GC_WR,
    ST_UP_RD, ST_UP_MUL, ST_UP_SUM, ST_UP_WR,
    ST_OUT
  } st_t;

  // Saturate a 40-bit signed value to 32 bits.
  function automatic logic signed [POS_W-1:0] sat40(input logic signed [39:0] a);
    logic signed [POS_W-1:0] r;
    if (a > 40'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (a < -40'sd2147483648) r = 32'sh8000_0000;
    else r = a[POS_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/psw_if.sv
// Channel interfaces of the particle swarm step unit.
`default_nettype none
interface psw_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [2:0]         particle;
  logic               dim;
  logic signed [31:0] load_position;
  logic signed [31:0] load_velocity;
  logic [16:0]        rand_cognitive;
  logic [16:0]        rand_social;
  modport source (output valid, op, particle, dim, load_position, load_velocity,
                  rand_cognitive, rand_social, input ready);
  modport sink (input valid, op, particle, dim, load_position, load_velocity,
                rand_cognitive, rand_social, output ready);
endinterface

interface psw_out_if;
  logic               valid;
  logic               ready;
  logic               out_dim;
  logic signed [31:0] best_value;
  logic [47:0]        best_fitness;
  logic               last;
  modport source (output valid, out_dim, best_value, best_fitness, last, input ready);
  modport sink (input valid, out_dim, best_value, best_fitness, last, output ready);
endinterface

interface psw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/psw_fit.sv
// Fitness accumulator: squares one element per transfer and sums with saturation.
`default_nettype none
module psw_fit #(
  parameter int DW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psw_pkg::fit_ctl_t   ctl,
  input  logic                mode,
  input  logic signed [31:0]  value,
  input  logic [DW-1:0]       idx,
  output logic [47:0]         acc
);
  import psw_pkg::*;

  logic [POS_W-1:0]    mag;
  logic [SQ_W-1:0]     sq_r;
  logic [DW-1:0]       idx_r;
  logic                vld_r;
  logic [FIT_W-1:0]    acc_r;
  logic [DW:0]         wt;
  logic [DW+48:0]      term;
  logic [DW+49:0]      sum;

  // Magnitude of the element; the most negative value maps to 2^31.
  assign mag = value[POS_W-1] ? POS_W'(-value) : value[POS_W-1:0];

  // Square stage.
  always_ff @(posedge clk) begin
    sq_r  <= SQ_W'(mag) * SQ_W'(mag);
    idx_r <= idx;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.vld;
    end
  end

  // Weight by dimension index in weighted mode, then saturating add.
  assign wt   = mode ? ((DW+1)'(idx_r) + (DW+1)'(1)) : (DW+1)'(1);
  assign term = (DW+49)'(sq_r[SQ_W-1:16]) * (DW+49)'(wt);
  assign sum  = (DW+50)'(acc_r) + (DW+50)'(term);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (vld_r) begin
      acc_r <= (sum > (DW+50)'(FIT_MAX)) ? FIT_MAX : sum[FIT_W-1:0];
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

>>> src/psw_upd.sv
// Velocity and position update datapath, two register stages.
`default_nettype none
module psw_upd (
  input  logic               clk,
  input  logic signed [31:0] x,
  input  logic signed [31:0] v,
  input  logic signed [31:0] b,
  input  logic signed [31:0] g,
  input  logic [17:0]        w,
  input  logic [19:0]        c1,
  input  logic [19:0]        c2,
  output logic signed [31:0] v_new,
  output logic signed [31:0] x_new
);
  import psw_pkg::*;

  logic signed [32:0]      db;
  logic signed [32:0]      dg;
  logic signed [50:0]      pw_r;
  logic signed [53:0]      p1_r;
  logic signed [53:0]      p2_r;
  logic signed [POS_W-1:0] x1_r;
  logic signed [39:0]      sum;
  logic signed [POS_W-1:0] v2_r;
  logic signed [POS_W-1:0] x2_r;

  assign db = 33'(b) - 33'(x);
  assign dg = 33'(g) - 33'(x);

  // Multiply stage: inertia, cognitive and social terms.
  always_ff @(posedge clk) begin
    pw_r <= $signed({1'b0, w}) * v;
    p1_r <= $signed({1'b0, c1}) * db;
    p2_r <= $signed({1'b0, c2}) * dg;
    x1_r <= x;
  end

  // Each term is floored by an arithmetic shift, then the sum saturates.
  assign sum = 40'(pw_r >>> 16) + 40'(p1_r >>> 16) + 40'(p2_r >>> 16);

  always_ff @(posedge clk) begin
    v2_r <= sat40(sum);
    x2_r <= x1_r;
  end

  assign v_new = v2_r;
  assign x_new = sat40(40'(x2_r) + 40'(v2_r));

endmodule
`default_nettype wire

>>> src/particle_swarm_step_unit.sv
// Top level of the particle swarm step unit: sequencer, state memories and result register.
//
//  Channel  | Direction | Transfer carries
//  ---------+-----------+-----------------------------------------------------------
//  in_ch    | sink      | op, particle, dim, load_position, load_velocity, e1, e2
//  out_ch   | source    | out_dim, best_value, best_fitness, last
//  cfg_ch   | sink      | index, data (always ready)
//
// A load is written straight from the idle state; the block stays ready. An
// iteration is sequenced through the state memories one element at a time:
// the personal best fitness and compare, a copy of the position into each
// replaced personal best, the global fitness, the global scan with a copy of
// each better best, the update of every element and then the results. Reset
// is synchronous; the memories need no clearing. out_ch stalls hold the
// sequencer in its result state; a last result may still wait while new
// items are taken.
`default_nettype none
module particle_swarm_step_unit #(
  parameter int PARTICLES  = 8,
  parameter int DIMENSIONS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  psw_in_if.sink      in_ch,
  psw_out_if.source   out_ch,
  psw_cfg_if.sink     cfg_ch
);
  import psw_pkg::*;

  localparam int ELEMS = PARTICLES * DIMENSIONS;
  localparam int AW    = (ELEMS > 1) ? $clog2(ELEMS) : 1;
  localparam int PW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int DW    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  st_t state_r, state_nxt;

  logic                mode_r;
  logic [W_W-1:0]      w_r;
  logic [F_W-1:0]      f1_r;
  logic [F_W-1:0]      f2_r;
  logic [C_W-1:0]      c1_r;
  logic [C_W-1:0]      c2_r;
  logic [F_W+E_W-1:0]  prod1;
  logic [F_W+E_W-1:0]  prod2;

  logic [PW-1:0]       i_r;
  logic [DW-1:0]       j_r;
  logic [AW-1:0]       addr_r;
  logic [AW-1:0]       base_r;
  logic [AW-1:0]       base_p;
  logic                lasti;
  logic                lastj;

  logic signed [POS_W-1:0] gbest_r [DIMENSIONS];
  logic [FIT_W-1:0]        gfit_r;
  logic [FIT_W-1:0]        ref_r;
  logic                    gvalid_r;

  logic signed [POS_W-1:0] pos_mem  [ELEMS];
  logic signed [POS_W-1:0] vel_mem  [ELEMS];
  logic signed [POS_W-1:0] pb_mem   [ELEMS];
  logic [FIT_W-1:0]        pfit_mem [PARTICLES];
  logic signed [POS_W-1:0] pos_rd_r;
  logic signed [POS_W-1:0] vel_rd_r;
  logic signed [POS_W-1:0] pb_rd_r;
  logic [FIT_W-1:0]        pfit_rd_r;

  logic                    in_acc;
  logic                    ld_we;
  logic [AW-1:0]           ld_addr;
  logic [AW-1:0]           wr_addr;
  logic                    pos_we, pb_we, pfit_we;
  logic signed [POS_W-1:0] pos_wd, vel_wd, pb_wd;

  fit_ctl_t                fit_ctl_a, fit_ctl_b;
  logic signed [POS_W-1:0] fit_val_a;
  logic [FIT_W-1:0]        fit_x, fit_b;
  logic                    repl;
  logic                    better;

  logic signed [POS_W-1:0] v_new, x_new;

  logic                    out_valid_r;
  logic                    out_dim_r;
  logic signed [POS_W-1:0] out_value_r;
  logic [FIT_W-1:0]        out_fit_r;
  logic                    out_last_r;
  logic                    out_load;

  // Handshakes.
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RST_MODE;
      w_r    <= RST_INERTIA;
      f1_r   <= RST_COG;
      f2_r   <= RST_SOC;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_MODE:    mode_r <= cfg_ch.data[0];
        CFG_INERTIA: w_r    <= cfg_ch.data[W_W-1:0];
        CFG_COG:     f1_r   <= cfg_ch.data[F_W-1:0];
        CFG_SOC:     f2_r   <= cfg_ch.data[F_W-1:0];
        default:     mode_r <= mode_r;
      endcase
    end
  end

  // Random-scaled gains, captured when an iteration is taken.
  assign prod1 = (F_W+E_W)'(f1_r) * (F_W+E_W)'(in_ch.rand_cognitive);
  assign prod2 = (F_W+E_W)'(f2_r) * (F_W+E_W)'(in_ch.rand_social);

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.op) begin
      c1_r <= prod1[F_W+E_W-1:16];
      c2_r <= prod2[F_W+E_W-1:16];
    end
  end

  assign lasti  = (i_r == PW'(PARTICLES - 1));
  assign lastj  = (j_r == DW'(DIMENSIONS - 1));
  assign base_p = base_r + AW'(DIMENSIONS);

  // Load address and range check.
  assign ld_addr = AW'(32'(in_ch.particle) * DIMENSIONS + 32'(in_ch.dim));
  assign ld_we   = in_acc && !in_ch.op &&
                   (32'(in_ch.particle) < 32'(PARTICLES)) &&
                   (32'(in_ch.dim) < 32'(DIMENSIONS));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_acc && in_ch.op) state_nxt = ST_PB_RD;
      ST_PB_RD:   state_nxt = ST_PB_SQ;
      ST_PB_SQ:   state_nxt = lastj ? ST_PB_WAIT : ST_PB_RD;
      ST_PB_WAIT: state_nxt = ST_PB_CMP;
      ST_PB_CMP: begin
        if (repl) state_nxt = ST_CP_RD;
        else state_nxt = lasti ? ST_GF_FEED : ST_PB_RD;
      end
      ST_CP_RD:   state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        if (!lastj) state_nxt = ST_CP_RD;
        else state_nxt = lasti ? ST_GF_FEED : ST_PB_RD;
      end
      ST_GF_FEED: state_nxt = lastj ? ST_GF_WAIT : ST_GF_FEED;
      ST_GF_WAIT: state_nxt = ST_GF_SET;
      ST_GF_SET:  state_nxt = ST_GS_RD;
      ST_GS_RD:   state_nxt = ST_GS_CMP;
      ST_GS_CMP: begin
        if (better) state_nxt = ST_GC_RD;
        else state_nxt = lasti ? ST_UP_RD : ST_GS_RD;
      end
      ST_GC_RD:   state_nxt = ST_GC_WR;
      ST_GC_WR: begin
        if (!lastj) state_nxt = ST_GC_RD;
        else state_nxt = lasti ? ST_UP_RD : ST_GS_RD;
      end
      ST_UP_RD:   state_nxt = ST_UP_MUL;
      ST_UP_MUL:  state_nxt = ST_UP_SUM;
      ST_UP_SUM:  state_nxt = ST_UP_WR;
      ST_UP_WR:   state_nxt = (lasti && lastj) ? ST_OUT : ST_UP_RD;
      ST_OUT:     if (out_load && lastj) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs: memory writes and fitness unit control.
  always_comb begin
    fit_ctl_a = '0;
    fit_ctl_b = '0;
    pos_we    = ld_we;
    pb_we     = ld_we;
    pfit_we   = 1'b0;
    pos_wd    = in_ch.load_position;
    vel_wd    = in_ch.load_velocity;
    pb_wd     = in_ch.load_position;
    fit_val_a = pos_rd_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        fit_ctl_a.clr = 1'b1;
        fit_ctl_b.clr = 1'b1;
      end
      ST_PB_SQ: begin
        fit_ctl_a.vld = 1'b1;
        fit_ctl_b.vld = 1'b1;
      end
      ST_PB_CMP: begin
        pfit_we       = 1'b1;
        fit_ctl_a.clr = 1'b1;
        fit_ctl_b.clr = 1'b1;
      end
      ST_CP_WR: begin
        pb_we = 1'b1;
        pb_wd = pos_rd_r;
      end
      ST_GF_FEED: begin
        fit_ctl_a.vld = 1'b1;
        fit_val_a     = gbest_r[j_r];
      end
      ST_UP_WR: begin
        pos_we = 1'b1;
        pos_wd = x_new;
        vel_wd = v_new;
      end
      ST_OUT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign wr_addr = (state_r == ST_IDLE) ? ld_addr : addr_r;
  assign repl    = (fit_b > fit_x);
  assign better  = (pfit_rd_r < ref_r);

  // State memories with registered reads; the sequence never reads an
  // entry in the cycle after it is written, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= pos_wd;
      vel_mem[wr_addr] <= vel_wd;
    end
    pos_rd_r <= pos_mem[addr_r];
    vel_rd_r <= vel_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      pb_mem[wr_addr] <= pb_wd;
    end
    pb_rd_r <= pb_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (pfit_we) begin
      pfit_mem[i_r] <= repl ? fit_x : fit_b;
    end
    pfit_rd_r <= pfit_mem[i_r];
  end

  // Fitness of position (A, also global best) and personal best (B).
  psw_fit #(.DW(DW)) u_fit_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fit_ctl_a),
    .mode  (mode_r),
    .value (fit_val_a),
    .idx   (j_r),
    .acc   (fit_x)
  );

  psw_fit #(.DW(DW)) u_fit_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fit_ctl_b),
    .mode  (mode_r),
    .value (pb_rd_r),
    .idx   (j_r),
    .acc   (fit_b)
  );

  psw_upd u_upd (
    .clk   (clk),
    .x     (pos_rd_r),
    .v     (vel_rd_r),
    .b     (pb_rd_r),
    .g     (gbest_r[j_r]),
    .w     (w_r),
    .c1    (c1_r),
    .c2    (c2_r),
    .v_new (v_new),
    .x_new (x_new)
  );

  // Counters and global best registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r      <= '0;
      j_r      <= '0;
      addr_r   <= '0;
      base_r   <= '0;
      gfit_r   <= '0;
      ref_r    <= '0;
      gvalid_r <= 1'b0;
      for (int d = 0; d < DIMENSIONS; d++) begin
        gbest_r[d] <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            i_r    <= '0;
            j_r    <= '0;
            addr_r <= '0;
            base_r <= '0;
            if (!in_ch.op) gvalid_r <= 1'b0;
          end
        end
        ST_PB_SQ: begin
          if (!lastj) begin
            addr_r <= addr_r + AW'(1);
            j_r    <= j_r + DW'(1);
          end
        end
        ST_PB_CMP: begin
          j_r <= '0;
          if (repl) begin
            addr_r <= base_r;
          end else if (lasti) begin
            i_r    <= '0;
            addr_r <= '0;
            base_r <= '0;
          end else begin
            i_r    <= i_r + PW'(1);
            addr_r <= base_p;
            base_r <= base_p;
          end
        end
        ST_CP_WR, ST_GC_WR: begin
          if (state_r == ST_GC_WR) gbest_r[j_r] <= pb_rd_r;
          if (!lastj) begin
            addr_r <= addr_r + AW'(1);
            j_r    <= j_r + DW'(1);
          end else begin
            j_r <= '0;
            if (lasti) begin
              i_r    <= '0;
              addr_r <= '0;
              base_r <= '0;
            end else begin
              i_r    <= i_r + PW'(1);
              addr_r <= base_p;
              base_r <= base_p;
            end
          end
        end
        ST_GF_FEED: begin
          j_r <= lastj ? '0 : j_r + DW'(1);
        end
        ST_GF_SET: begin
          ref_r    <= gvalid_r ? fit_x : FIRST_REF;
          gfit_r   <= fit_x;
          gvalid_r <= 1'b1;
        end
        ST_GS_CMP: begin
          if (better) begin
            ref_r  <= pfit_rd_r;
            gfit_r <= pfit_rd_r;
          end else if (lasti) begin
            i_r    <= '0;
            addr_r <= '0;
            base_r <= '0;
          end else begin
            i_r    <= i_r + PW'(1);
            addr_r <= base_p;
            base_r <= base_p;
          end
        end
        ST_UP_WR: begin
          addr_r <= addr_r + AW'(1);
          if (lastj) begin
            j_r <= '0;
            i_r <= lasti ? '0 : i_r + PW'(1);
          end else begin
            j_r <= j_r + DW'(1);
          end
        end
        ST_OUT: begin
          if (out_load) j_r <= lastj ? '0 : j_r + DW'(1);
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dim_r   <= j_r[0];
      out_value_r <= gbest_r[j_r];
      out_fit_r   <= gfit_r;
      out_last_r  <= lastj;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_dim      = out_dim_r;
  assign out_ch.best_value   = out_value_r;
  assign out_ch.best_fitness = out_fit_r;
  assign out_ch.last         = out_last_r;

endmodule
`default_nettype wire

>>> src/psw_chk.sv
// Port-level checker for the particle swarm step unit and its bind.
`default_nettype none
module psw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_value
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  // An iteration transfer makes the block busy.
  a_iter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("input ready right after an iteration");

  // A load transfer leaves the input ready.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op |=> in_ready)
    else $error("input not ready after a load");

  // While a vector is only partly reported, no new item is taken.
  a_vec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a result vector");

endmodule

bind particle_swarm_step_unit psw_chk u_psw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last),
  .out_value (out_ch.best_value)
);
`default_nettype wire

>>> dv/psw_tb_pkg.sv
// Shared constants of the particle swarm step unit testbench.
`timescale 1ns / 100ps
package psw_tb_pkg;
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ITERATE = 1'b1;
  localparam int   NUM_PART   = 8;
  localparam int   NUM_DIM    = 2;
endpackage

>>> dv/tb_particle_swarm_step_unit.sv
// Testbench of the particle swarm step unit: directed table, random swarms, scoreboard.
`timescale 1ns / 100ps
module tb_particle_swarm_step_unit;
  import psw_pkg::*;
  import psw_tb_pkg::*;

  typedef struct {
    logic              op;
    logic [2:0]        particle;
    logic              dim;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic [16:0]       e1;
    logic [16:0]       e2;
  } swarm_item_t;

  typedef struct {
    logic              dim;
    logic signed [31:0] value;
    logic [47:0]       fit;
    logic              last;
  } best_report_t;

  // Directed row: an item with an optional typed-in expectation for both results.
  typedef struct {
    swarm_item_t  item;
    bit           typed;
    logic signed [31:0] v0, v1;
    logic [47:0]  f;
  } swarm_row_t;

  logic clk, rst_n;
  psw_in_if  in_ch();
  psw_out_if out_ch();
  psw_cfg_if cfg_ch();

  particle_swarm_step_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                .out_ch(out_ch), .cfg_ch(cfg_ch));

  // Predictor state.
  logic               mode_q;
  logic [17:0]        w_q;
  logic [18:0]        f1_q, f2_q;
  logic signed [31:0] pos_m[NUM_PART][NUM_DIM];
  logic signed [31:0] vel_m[NUM_PART][NUM_DIM];
  logic signed [31:0] pb_m[NUM_PART][NUM_DIM];
  logic signed [31:0] gb_m[NUM_DIM];
  logic               gvalid;
  best_report_t       best_q[$];
  int                 errors;
  longint             cycles;
  bit                 rcv_stall_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Fitness of a vector: floored squares, optionally weighted, saturating sum.
  function automatic logic [47:0] vec_fitness(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic [63:0] m0, m1, t0, t1;
    logic [65:0] s;
    m0 = a < 0 ? 64'(-longint'(a)) : 64'(a);
    m1 = b < 0 ? 64'(-longint'(b)) : 64'(b);
    t0 = (m0 * m0) >> 16;
    t1 = (m1 * m1) >> 16;
    if (mode_q) t1 = t1 * 2;
    s = t0;
    if (s > 66'(FIT_MAX)) s = FIT_MAX;
    s = s + t1;
    if (s > 66'(FIT_MAX)) s = FIT_MAX;
    return s[47:0];
  endfunction

  function automatic longint floor_q16(input longint a);
    return a >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint a);
    if (a > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (a < -64'sd2147483648) return 32'sh8000_0000;
    return a[31:0];
  endfunction

  // Apply one item to the swarm predictor and queue the reports it causes.
  task automatic predict_swarm(input swarm_item_t it);
    logic [47:0] pf[NUM_PART];
    logic [47:0] fb, fx, bound, gf;
    longint c1, c2, x, nv;
    best_report_t r;
    if (it.op == OP_LOAD) begin
      gvalid = 1'b0;
      pos_m[it.particle][it.dim] = it.pos;
      vel_m[it.particle][it.dim] = it.vel;
      pb_m[it.particle][it.dim]  = it.pos;
      return;
    end
    for (int i = 0; i < NUM_PART; i++) begin
      fb = vec_fitness(pb_m[i][0], pb_m[i][1]);
      fx = vec_fitness(pos_m[i][0], pos_m[i][1]);
      if (fb > fx) begin
        pb_m[i] = pos_m[i];
        fb = fx;
      end
      pf[i] = fb;
    end
    bound = gvalid ? vec_fitness(gb_m[0], gb_m[1]) : FIRST_REF;
    for (int i = 0; i < NUM_PART; i++) begin
      if (pf[i] < bound) begin
        bound = pf[i];
        gb_m = pb_m[i];
      end
    end
    gvalid = 1'b1;
    gf = vec_fitness(gb_m[0], gb_m[1]);
    c1 = longint'((64'(f1_q) * 64'(it.e1)) >> 16);
    c2 = longint'((64'(f2_q) * 64'(it.e2)) >> 16);
    for (int i = 0; i < NUM_PART; i++) begin
      for (int j = 0; j < NUM_DIM; j++) begin
        x = pos_m[i][j];
        nv = floor_q16(longint'(w_q) * longint'(vel_m[i][j]))
           + floor_q16(c1 * (longint'(pb_m[i][j]) - x))
           + floor_q16(c2 * (longint'(gb_m[j]) - x));
        vel_m[i][j] = clamp32(nv);
        pos_m[i][j] = clamp32(x + longint'(vel_m[i][j]));
      end
    end
    for (int j = 0; j < NUM_DIM; j++) begin
      r.dim = j[0];
      r.value = gb_m[j];
      r.fit = gf;
      r.last = (j == NUM_DIM - 1);
      best_q.push_back(r);
    end
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    best_report_t e;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (best_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = best_q.pop_front();
        if (out_ch.out_dim !== e.dim) begin
          $error("out_dim exp %0d got %0d", e.dim, out_ch.out_dim);
          errors++;
        end
        if (out_ch.best_value !== e.value) begin
          $error("best_value exp %0d got %0d", e.value, out_ch.best_value);
          errors++;
        end
        if (out_ch.best_fitness !== e.fit) begin
          $error("best_fitness exp %0d got %0d", e.fit, out_ch.best_fitness);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern: stretches of free flow and of heavy stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rcv_stall_on) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0) ?
                      (cycles[6] | 1'($urandom_range(0, 1))) : 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Run-time guard.
  always @(posedge clk) begin
    if (cycles > 64'd3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input swarm_item_t it);
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.particle       <= it.particle;
    in_ch.dim            <= it.dim;
    in_ch.load_position  <= it.pos;
    in_ch.load_velocity  <= it.vel;
    in_ch.rand_cognitive <= it.e1;
    in_ch.rand_social    <= it.e2;
    do @(posedge clk); while (!in_ch.ready);
    predict_swarm(it);
  endtask

  // Drop valid, then wait a random gap; bursts are shaped by the caller.
  task automatic sender_gap(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One register write, followed by a wait with valid low so it drops between writes.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MODE:    mode_q = val[0];
      CFG_INERTIA: w_q = val[17:0];
      CFG_COG:     f1_q = val[18:0];
      CFG_SOC:     f2_q = val[18:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Quiesce: all expected results drained, then a settling wait with valid low.
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    while (best_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic swarm_item_t load_of(input int p, input int d,
                                          input logic [31:0] x, input logic [31:0] v);
    swarm_item_t it;
    it = '{OP_LOAD, p[2:0], d[0], x, v, 17'($urandom), 17'($urandom)};
    return it;
  endfunction

  function automatic swarm_item_t iter_of(input logic [16:0] e1, input logic [16:0] e2);
    swarm_item_t it;
    it = '{OP_ITERATE, 3'($urandom), 1'($urandom), $urandom, $urandom, e1, e2};
    return it;
  endfunction

  // Random Q16.16 value: mostly modest, sometimes extreme.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000);
    endcase
  endfunction

  // Load the whole swarm; every entry is written before any iteration.
  task automatic load_swarm(input bit extreme);
    for (int p = 0; p < NUM_PART; p++) begin
      for (int d = 0; d < NUM_DIM; d++) begin
        send_item(load_of(p, d, extreme ? rand_coord() : rand_coord(), rand_coord()));
        if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 6));
      end
    end
  endtask

  swarm_row_t dir_tab[$];
  swarm_row_t row;
  int sent;

  initial begin
    errors = 0;
    cycles = 0;
    rcv_stall_on = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.particle = '0;
    in_ch.dim = 1'b0;
    in_ch.load_position = '0;
    in_ch.load_velocity = '0;
    in_ch.rand_cognitive = '0;
    in_ch.rand_social = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MODE;
    cfg_ch.data = '0;
    mode_q = RST_MODE;
    w_q = RST_INERTIA;
    f1_q = RST_COG;
    f2_q = RST_SOC;
    gvalid = 1'b0;
    gb_m = '{0, 0};
    for (int p = 0; p < NUM_PART; p++) begin
      pos_m[p] = '{0, 0};
      vel_m[p] = '{0, 0};
      pb_m[p] = '{0, 0};
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Zero swarm with reset gains: best stays zero, fitness zero.
    for (int p = 0; p < NUM_PART; p++)
      for (int d = 0; d < NUM_DIM; d++)
        dir_tab.push_back('{load_of(p, d, 32'd0, 32'd0), 1'b0, 0, 0, 48'd0});
    dir_tab.push_back('{iter_of(17'd0, 17'd0), 1'b1, 32'sd0, 32'sd0, 48'd0});
    // Random factors at one and above one, then at zero.
    dir_tab.push_back('{iter_of(17'd65536, 17'h1FFFF), 1'b1, 32'sd0, 32'sd0, 48'd0});
    // Out-of-range style loads do not exist at 8x2, but any load re-arms the first pass.
    dir_tab.push_back('{load_of(3, 1, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0, 0, 0, 48'd0});
    dir_tab.push_back('{load_of(3, 0, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0, 0, 0, 48'd0});
    dir_tab.push_back('{iter_of(17'h1FFFF, 17'd0), 1'b0, 0, 0, 48'd0});
    dir_tab.push_back('{iter_of(17'd0, 17'd65536), 1'b0, 0, 0, 48'd0});
    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      send_item(row.item);
      // The two newest expectations belong to this row.
      if (row.typed && (best_q.size() < 2
          || best_q[best_q.size() - 2].value !== row.v0
          || best_q[best_q.size() - 1].value !== row.v1
          || best_q[best_q.size() - 1].fit !== row.f)) begin
        $error("directed expectation mismatch row %0d", k);
        errors++;
      end
    end
    drain_all();

    // Extremes of every register, including weighted fitness.
    write_reg(CFG_MODE, 32'd1);
    write_reg(CFG_INERTIA, 32'h3FFFF);
    write_reg(CFG_COG, 32'h7FFFF);
    write_reg(CFG_SOC, 32'h7FFFF);
    load_swarm(1'b1);
    repeat (3) send_item(iter_of(17'($urandom), 17'($urandom)));
    drain_all();
    write_reg(CFG_MODE, 32'd0);
    write_reg(CFG_INERTIA, 32'd0);
    write_reg(CFG_COG, 32'd0);
    write_reg(CFG_SOC, 32'd0);
    load_swarm(1'b1);
    repeat (2) send_item(iter_of(17'd65536, 17'd65536));
    drain_all();

    // Random phases: fresh gains, a full swarm load, then a run of iterations.
    sent = 0;
    rcv_stall_on = 1'b1;
    while (sent < 1550) begin
      write_reg(CFG_MODE, $urandom_range(0, 1));
      write_reg(CFG_INERTIA, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(20000, 60000));
      write_reg(CFG_COG, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(50000, 140000));
      write_reg(CFG_SOC, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(50000, 140000));
      rcv_stall_on = $urandom_range(0, 3) != 0;
      load_swarm(1'b0);
      sent += 2 * NUM_PART;
      repeat ($urandom_range(4, 14)) begin
        // Occasional reload of one element mid-run re-arms the first iteration.
        if ($urandom_range(0, 7) == 0) begin
          send_item(load_of($urandom_range(0, 7), $urandom_range(0, 1), rand_coord(),
                            rand_coord()));
          sent++;
        end
        send_item(iter_of($urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                          $urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536))));
        sent++;
        if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 40));
      end
      drain_all();
    end

    drain_all();
    if (errors == 0 && best_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/psw_pkg.sv
src/psw_if.sv
src/psw_fit.sv
src/psw_upd.sv
src/particle_swarm_step_unit.sv
src/psw_chk.sv
dv/psw_tb_pkg.sv
dv/tb_particle_swarm_step_unit.sv
